// ----- src/mtg_pkg.sv -----
// mtg_pkg: shared types, constants and the tempering function of the MT19937 core.
// No dependencies; used by mtg_ram and mt19937_generator_core.
package mtg_pkg;

    localparam int unsigned N_WORDS  = 624;
    localparam int unsigned M_OFFSET = 397;
    localparam int unsigned ADDR_W   = 10;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [31:0]       word_t;

    localparam addr_t LAST_ADDR   = addr_t'(N_WORDS - 1);
    localparam addr_t POS_END     = addr_t'(N_WORDS);
    localparam addr_t M_ADDR      = addr_t'(M_OFFSET);
    localparam addr_t TWIST_SPLIT = addr_t'(N_WORDS - M_OFFSET);

    localparam word_t MATRIX_A  = 32'h9908b0df;
    localparam word_t UPPER     = 32'h80000000;
    localparam word_t LOWER     = 32'h7fffffff;
    localparam word_t TEMPER_B  = 32'h9d2c5680;
    localparam word_t TEMPER_C  = 32'hefc60000;
    localparam word_t INIT_MULT = 32'd1812433253;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_MUL,
        ST_SEED_ADD,
        ST_TWIST,
        ST_TW_DRAIN,
        ST_DRAW_OUT
    } state_t;

    // one write port, two read ports
    typedef struct packed {
        logic  wr_en;
        addr_t wr_addr;
        word_t wr_data;
        logic  rd_en;
        addr_t rd_addr_a;
        addr_t rd_addr_b;
    } ram_req_t;

    function automatic word_t temper(input word_t w);
        word_t v;
        v = w;
        v = v ^ (v >> 11);
        v = v ^ ((v << 7) & TEMPER_B);
        v = v ^ ((v << 15) & TEMPER_C);
        v = v ^ (v >> 18);
        return v;
    endfunction

endpackage

// ----- src/mtg_ram.sv -----
// mtg_ram: 624 x 32 state store, one write port and two registered read ports.
// Depends on mtg_pkg.
module mtg_ram (
    input  logic              clk,
    input  mtg_pkg::ram_req_t req,
    output mtg_pkg::word_t    rd_data_a,
    output mtg_pkg::word_t    rd_data_b
);

    mtg_pkg::word_t mem [mtg_pkg::N_WORDS];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // read data holds between reads
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_a <= mem[req.rd_addr_a];
            rd_data_b <= mem[req.rd_addr_b];
        end
    end

endmodule

// ----- src/mt19937_generator_core.sv -----
// mt19937_generator_core: MT19937 core, 624-word store in a RAM, sequential control.
// Depends on mtg_pkg and mtg_ram.
//
//   channel | signals                              | direction | meaning
//   --------+--------------------------------------+-----------+--------------------------
//   in      | in_valid, in_stall, mode, seed_value | to core   | draw (mode 0) / reseed (1)
//   out     | out_valid, out_stall, random_value   | from core | one tempered word per draw
//
// Draw: the word is read when the draw is taken and tempered into the output
// register in ST_DRAW_OUT. A draw that runs past the end of the store first
// twists it in place, one word per cycle through the two RAM read ports. A
// reseed runs the init recurrence serially, a multiply and an add/write state per word.
// Reset: no clearing pass. A seeded flag stands for the all-zero store, which
// twists to zero, so draws before the first reseed return 0 without the RAM.
// Stalls: in_stall is high while a transaction is in work. The result sits in
// an output register; a draw waits in ST_DRAW_OUT only while that is full and out_stall is high.
module mt19937_generator_core (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [31:0] seed_value,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] random_value
);

    mtg_pkg::state_t   state_reg, state_next;
    mtg_pkg::addr_t    pos_reg, pos_next;        // read position
    mtg_pkg::addr_t    cnt_reg, cnt_next;        // twist issue counter, 0..624
    mtg_pkg::addr_t    idx_reg, idx_next;        // seed fill index
    logic              seeded_reg, seeded_next;
    logic              ex_valid_reg, ex_valid_next;
    logic              ex_prime_reg, ex_prime_next;
    mtg_pkg::addr_t    ex_k_reg, ex_k_next;
    mtg_pkg::word_t    prev_reg, prev_next;
    mtg_pkg::word_t    prod_reg, prod_next;
    mtg_pkg::word_t    cur_reg, cur_next;        // w[k] for the twist step in execute
    logic              out_valid_reg, out_valid_next;
    mtg_pkg::word_t    out_data_reg, out_data_next;

    mtg_pkg::ram_req_t ram_req;
    mtg_pkg::word_t    rd_a;
    mtg_pkg::word_t    rd_b;

    mtg_pkg::addr_t    tw_k;
    mtg_pkg::word_t    tw_y;
    mtg_pkg::word_t    tw_word;
    mtg_pkg::word_t    seed_word;
    logic              out_free;

    mtg_ram u_ram (
        .clk       (clk),
        .req       (ram_req),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    assign in_stall     = (state_reg != mtg_pkg::ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign random_value = out_data_reg;

    assign out_free  = !out_valid_reg || !out_stall;
    assign tw_k      = cnt_reg - mtg_pkg::addr_t'(1);
    // twist step on w[k] (cur_reg), w[k+1] (port a), w[k+397] (port b)
    assign tw_y      = (cur_reg & mtg_pkg::UPPER) | (rd_a & mtg_pkg::LOWER);
    assign tw_word   = rd_b ^ (tw_y >> 1) ^ (tw_y[0] ? mtg_pkg::MATRIX_A : '0);
    assign seed_word = prod_reg + mtg_pkg::word_t'(idx_reg);

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        seeded_next    = seeded_reg;
        ex_valid_next  = 1'b0;
        ex_prime_next  = ex_prime_reg;
        ex_k_next      = ex_k_reg;
        prev_next      = prev_reg;
        prod_next      = prod_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        ram_req        = '0;

        unique case (state_reg)
            mtg_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (mode)
                    begin
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = '0;
                        ram_req.wr_data = seed_value;
                        prev_next       = seed_value;
                        idx_next        = mtg_pkg::addr_t'(1);
                        state_next      = mtg_pkg::ST_SEED_MUL;
                    end
                    else if (seeded_reg && (pos_reg >= mtg_pkg::POS_END))
                    begin
                        cnt_next   = '0;
                        state_next = mtg_pkg::ST_TWIST;
                    end
                    else
                    begin
                        ram_req.rd_en     = seeded_reg;
                        ram_req.rd_addr_a = pos_reg;
                        state_next        = mtg_pkg::ST_DRAW_OUT;
                    end
                end
            end

            mtg_pkg::ST_SEED_MUL:
            begin
                prod_next  = mtg_pkg::INIT_MULT * (prev_reg ^ (prev_reg >> 30));
                state_next = mtg_pkg::ST_SEED_ADD;
            end

            mtg_pkg::ST_SEED_ADD:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = idx_reg;
                ram_req.wr_data = seed_word;
                prev_next       = seed_word;
                if (idx_reg == mtg_pkg::LAST_ADDR)
                begin
                    pos_next    = mtg_pkg::POS_END;
                    seeded_next = 1'b1;
                    state_next  = mtg_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + mtg_pkg::addr_t'(1);
                    state_next = mtg_pkg::ST_SEED_MUL;
                end
            end

            mtg_pkg::ST_TWIST:
            begin
                // count 0 primes cur_reg with w[0]; count k+1 issues reads for step k
                ram_req.rd_en = 1'b1;
                ex_valid_next = 1'b1;
                ex_prime_next = (cnt_reg == '0);
                ex_k_next     = tw_k;
                if (cnt_reg == '0)
                begin
                    ram_req.rd_addr_a = '0;
                end
                else
                begin
                    ram_req.rd_addr_a = (tw_k == mtg_pkg::LAST_ADDR) ? '0
                                        : tw_k + mtg_pkg::addr_t'(1);
                    ram_req.rd_addr_b = (tw_k >= mtg_pkg::TWIST_SPLIT)
                                        ? tw_k - mtg_pkg::TWIST_SPLIT
                                        : tw_k + mtg_pkg::M_ADDR;
                end
                if (cnt_reg == mtg_pkg::POS_END)
                begin
                    state_next = mtg_pkg::ST_TW_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + mtg_pkg::addr_t'(1);
                end
            end

            mtg_pkg::ST_TW_DRAIN:
            begin
                // last step retires while word 0 is fetched for the draw
                ram_req.rd_en     = 1'b1;
                ram_req.rd_addr_a = '0;
                pos_next          = '0;
                state_next        = mtg_pkg::ST_DRAW_OUT;
            end

            mtg_pkg::ST_DRAW_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = seeded_reg ? mtg_pkg::temper(rd_a) : '0;
                    pos_next       = pos_reg + mtg_pkg::addr_t'(1);
                    state_next     = mtg_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = mtg_pkg::ST_IDLE;
            end
        endcase

        // twist execute stage, in the cycle after issue
        if (ex_valid_reg)
        begin
            cur_next = rd_a;
            if (!ex_prime_reg)
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = ex_k_reg;
                ram_req.wr_data = tw_word;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mtg_pkg::ST_IDLE;
            pos_reg       <= mtg_pkg::POS_END;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            seeded_reg    <= 1'b0;
            ex_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            seeded_reg    <= seeded_next;
            ex_valid_reg  <= ex_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ex_prime_reg <= ex_prime_next;
        ex_k_reg     <= ex_k_next;
        prev_reg     <= prev_next;
        prod_reg     <= prod_next;
        cur_reg      <= cur_next;
        out_data_reg <= out_data_next;
    end

    // once seeded, the position never runs beyond the end of the store
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        seeded_reg |-> (pos_reg <= mtg_pkg::POS_END))
        else $error("read position beyond store end");

    // a draw reads a valid word: position is inside the store on the result cycle
    a_draw_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mtg_pkg::ST_DRAW_OUT && seeded_reg) |-> (pos_reg < mtg_pkg::POS_END))
        else $error("draw at position past the end");

    // twist write never hits an entry being read in the same cycle
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_req.wr_en && ram_req.rd_en && ex_valid_reg) |->
            (ram_req.wr_addr != ram_req.rd_addr_a && ram_req.wr_addr != ram_req.rd_addr_b))
        else $error("twist read/write overlap");

    // execute stage only follows a twist issue cycle
    a_ex_origin: assert property (@(posedge clk) disable iff (!rst_n)
        ex_valid_reg |-> ($past(state_reg) == mtg_pkg::ST_TWIST))
        else $error("twist execute without issue");

endmodule
